>>> src/assert_macros.svh
// assertion macros shared by the frustum cull rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked every clock, masked while reset is asserted
`define FSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define FSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/fsc_pkg.sv
// types, widths and register codes for the frustum sphere cull unit
// no dependencies; used by the sphere channel interface and the top level
package fsc_pkg;

	localparam int PLANES   = 6;
	localparam int COLS     = 4;
	localparam int ROW_W    = 64;
	localparam int ENTRY_W  = 16;
	localparam int COEF_W   = 17;
	localparam int CENTER_W = 24;
	localparam int RADIUS_W = 23;
	localparam int PROD_W   = 41;
	localparam int DIST_W   = 43;
	localparam int LEN2_W   = 34;
	localparam int RSQ_W    = 46;
	localparam int MAG_W    = 42;
	localparam int HALF_W   = MAG_W / 2;
	localparam int PP_W     = 2 * HALF_W;
	localparam int RSQ_LO_W = 23;
	localparam int LEN_LO_W = 17;
	localparam int PR_W     = 40;
	localparam int WIDE_W   = 84;
	localparam int ONE_SHIFT = 12;
	localparam int ADDR_W   = 5;

	typedef logic [ROW_W-1:0]           row_t;
	typedef logic signed [ENTRY_W-1:0]  entry_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [CENTER_W-1:0] center_t;
	typedef logic [RADIUS_W-1:0]        radius_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [DIST_W-1:0]   dist_t;
	typedef logic [LEN2_W-1:0]          len2_t;
	typedef logic [RSQ_W-1:0]           rsq_t;
	typedef logic [MAG_W-1:0]           mag_t;
	typedef logic [PP_W-1:0]            pp_t;
	typedef logic [PR_W-1:0]            pr_t;
	typedef logic [WIDE_W-1:0]          wide_t;

	// register codes, taken from paddr[4:3]
	localparam logic [1:0] REG_ROW_X = 2'd0;
	localparam logic [1:0] REG_ROW_Y = 2'd1;
	localparam logic [1:0] REG_ROW_Z = 2'd2;
	localparam logic [1:0] REG_ROW_W = 2'd3;

	// identity matrix at reset, 1.0 is 0x1000 in q4.12
	localparam row_t ROW_X_RESET = 64'h0000_0000_0000_1000;
	localparam row_t ROW_Y_RESET = 64'h0000_0000_1000_0000;
	localparam row_t ROW_Z_RESET = 64'h0000_1000_0000_0000;
	localparam row_t ROW_W_RESET = 64'h1000_0000_0000_0000;

	// signed q4.12 entry of a packed row
	function automatic entry_t entry_of(row_t row, int col);
		return entry_t'(row[ENTRY_W*col +: ENTRY_W]);
	endfunction

endpackage

>>> src/fsc_sphere_if.sv
// sphere channel: valid/ready handshake with centre and radius payload
// depends on fsc_pkg for field types
interface fsc_sphere_if;
	logic              valid;
	logic              ready;
	fsc_pkg::center_t  center_x;
	fsc_pkg::center_t  center_y;
	fsc_pkg::center_t  center_z;
	fsc_pkg::radius_t  radius;

	modport source (output valid, output center_x, output center_y, output center_z,
		output radius, input ready);
	modport sink (input valid, input center_x, input center_y, input center_z,
		input radius, output ready);
endinterface

>>> src/fsc_result_if.sv
// result channel: valid/ready handshake carrying the visibility flag
// no package dependencies
interface fsc_result_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, output visible, input ready);
	modport sink (input valid, input visible, output ready);
endinterface

>>> src/frustum_sphere_cull_unit.sv
// frustum sphere cull unit: six-plane sphere visibility test, six-stage pipeline
// depends on fsc_pkg, fsc_sphere_if, fsc_result_if and assert_macros.svh
//
//   channel   dir  handshake            payload
//   sphere    in   valid / ready        center_x, center_y, center_z, radius
//   result    out  valid / ready        visible
//   apb       in   psel/penable/pready  matrix rows 0..3 at paddr 0, 8, 16, 24
//
// one transaction per cycle while the result is taken; a sphere passes the input register
// then one stage for each multiplier bank and wide adder of the plane lanes
// arst_n clears valid bits and reloads the identity matrix; no clearing pass
// a stalled result holds the output stage; bubbles ahead of it still close up,
// each stage taking new data whenever it is empty or the stage after it moves
`include "assert_macros.svh"

module frustum_sphere_cull_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	fsc_sphere_if.sink                   sphere,
	fsc_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [fsc_pkg::ROW_W-1:0]    pwdata,
	output logic [fsc_pkg::ROW_W-1:0]    prdata,
	output logic                         pready
);

	localparam int P = fsc_pkg::PLANES;
	localparam int H = fsc_pkg::HALF_W;
	localparam int RL = fsc_pkg::RSQ_LO_W;
	localparam int LL = fsc_pkg::LEN_LO_W;

	fsc_pkg::row_t row_x_q, row_y_q, row_z_q, row_w_q;
	fsc_pkg::row_t rows [3];
	fsc_pkg::coef_t coef_q [P][fsc_pkg::COLS];
	fsc_pkg::len2_t len2_q [P];
	fsc_pkg::len2_t len2_d [P];

	logic en1, en2, en3, en4, en5, en6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	fsc_pkg::center_t cx_s1, cy_s1, cz_s1;
	fsc_pkg::radius_t rad_s1;
	fsc_pkg::prod_t prod_d [P][3];
	fsc_pkg::prod_t prod_s2 [P][3];
	fsc_pkg::rsq_t rsq_s2, rsq_s3, rsq_s4;
	fsc_pkg::dist_t dist_d [P];
	fsc_pkg::dist_t dist_s3 [P];
	fsc_pkg::mag_t mag_d [P];
	logic [P-1:0] neg_s4, neg_s5;
	fsc_pkg::pp_t pp_hh_d [P], pp_hl_d [P], pp_ll_d [P];
	fsc_pkg::pp_t pp_hh_s4 [P], pp_hl_s4 [P], pp_ll_s4 [P];
	fsc_pkg::pr_t pr_hh_d [P], pr_hl_d [P], pr_lh_d [P], pr_ll_d [P];
	fsc_pkg::pr_t pr_hh_s4 [P], pr_hl_s4 [P], pr_lh_s4 [P], pr_ll_s4 [P];
	fsc_pkg::wide_t lhs_d [P], rhs_d [P];
	fsc_pkg::wide_t lhs_s5 [P], rhs_s5 [P];
	logic [P-1:0] cull_d;
	logic visible_s6;

	// configuration port: writes on the access phase, reads from the row registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q <= fsc_pkg::ROW_X_RESET;
			row_y_q <= fsc_pkg::ROW_Y_RESET;
			row_z_q <= fsc_pkg::ROW_Z_RESET;
			row_w_q <= fsc_pkg::ROW_W_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:3])
				fsc_pkg::REG_ROW_X: row_x_q <= pwdata;
				fsc_pkg::REG_ROW_Y: row_y_q <= pwdata;
				fsc_pkg::REG_ROW_Z: row_z_q <= pwdata;
				fsc_pkg::REG_ROW_W: row_w_q <= pwdata;
				default: row_x_q <= row_x_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			fsc_pkg::REG_ROW_X: prdata = row_x_q;
			fsc_pkg::REG_ROW_Y: prdata = row_y_q;
			fsc_pkg::REG_ROW_Z: prdata = row_z_q;
			fsc_pkg::REG_ROW_W: prdata = row_w_q;
			default: prdata = '0;
		endcase
	end

	// plane coefficients, row w plus or minus rows x, y, z; refreshed every cycle
	assign rows[0] = row_x_q;
	assign rows[1] = row_y_q;
	assign rows[2] = row_z_q;

	always_ff @(posedge clk) begin
		for (int p = 0; p < P; p++) begin
			for (int k = 0; k < fsc_pkg::COLS; k++) begin
				if (p % 2 == 1)
					coef_q[p][k] <= fsc_pkg::coef_t'(fsc_pkg::entry_of(row_w_q, k))
						- fsc_pkg::coef_t'(fsc_pkg::entry_of(rows[p/2], k));
				else
					coef_q[p][k] <= fsc_pkg::coef_t'(fsc_pkg::entry_of(row_w_q, k))
						+ fsc_pkg::coef_t'(fsc_pkg::entry_of(rows[p/2], k));
			end
			len2_q[p] <= len2_d[p];
		end
	end

	// squared normal length per plane
	always_comb begin
		for (int p = 0; p < P; p++)
			len2_d[p] = fsc_pkg::len2_t'(
				34'(coef_q[p][0]) * 34'(coef_q[p][0])
				+ 34'(coef_q[p][1]) * 34'(coef_q[p][1])
				+ 34'(coef_q[p][2]) * 34'(coef_q[p][2]));
	end

	// stage enables: a stage moves when empty or when the next one moves
	assign en6 = !vld_s6 || result.ready;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign sphere.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= sphere.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (en1) begin
			cx_s1  <= sphere.center_x;
			cy_s1  <= sphere.center_y;
			cz_s1  <= sphere.center_z;
			rad_s1 <= sphere.radius;
		end
	end

	// stage 2: coefficient times centre products, radius squared
	always_comb begin
		for (int p = 0; p < P; p++) begin
			prod_d[p][0] = fsc_pkg::prod_t'(41'(coef_q[p][0]) * 41'(cx_s1));
			prod_d[p][1] = fsc_pkg::prod_t'(41'(coef_q[p][1]) * 41'(cy_s1));
			prod_d[p][2] = fsc_pkg::prod_t'(41'(coef_q[p][2]) * 41'(cz_s1));
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2 <= prod_d;
			rsq_s2  <= fsc_pkg::rsq_t'(46'(rad_s1) * 46'(rad_s1));
		end
	end

	// stage 3: signed distance, offset term scaled by 1.0 in q12.12
	always_comb begin
		for (int p = 0; p < P; p++)
			dist_d[p] = 43'(prod_s2[p][0]) + 43'(prod_s2[p][1]) + 43'(prod_s2[p][2])
				+ (43'(coef_q[p][3]) <<< fsc_pkg::ONE_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			dist_s3 <= dist_d;
			rsq_s3  <= rsq_s2;
		end
	end

	// stage 4: magnitude and split partial products of both squared sides
	always_comb begin
		for (int p = 0; p < P; p++) begin
			mag_d[p] = dist_s3[p][fsc_pkg::DIST_W-1] ? fsc_pkg::mag_t'(-dist_s3[p])
				: fsc_pkg::mag_t'(dist_s3[p]);
			pp_hh_d[p] = fsc_pkg::pp_t'(42'(mag_d[p][2*H-1:H]) * 42'(mag_d[p][2*H-1:H]));
			pp_hl_d[p] = fsc_pkg::pp_t'(42'(mag_d[p][2*H-1:H]) * 42'(mag_d[p][H-1:0]));
			pp_ll_d[p] = fsc_pkg::pp_t'(42'(mag_d[p][H-1:0]) * 42'(mag_d[p][H-1:0]));
			pr_hh_d[p] = fsc_pkg::pr_t'(40'(rsq_s3[fsc_pkg::RSQ_W-1:RL])
				* 40'(len2_q[p][fsc_pkg::LEN2_W-1:LL]));
			pr_hl_d[p] = fsc_pkg::pr_t'(40'(rsq_s3[fsc_pkg::RSQ_W-1:RL])
				* 40'(len2_q[p][LL-1:0]));
			pr_lh_d[p] = fsc_pkg::pr_t'(40'(rsq_s3[RL-1:0])
				* 40'(len2_q[p][fsc_pkg::LEN2_W-1:LL]));
			pr_ll_d[p] = fsc_pkg::pr_t'(40'(rsq_s3[RL-1:0]) * 40'(len2_q[p][LL-1:0]));
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int p = 0; p < P; p++)
				neg_s4[p] <= dist_s3[p][fsc_pkg::DIST_W-1];
			pp_hh_s4 <= pp_hh_d;
			pp_hl_s4 <= pp_hl_d;
			pp_ll_s4 <= pp_ll_d;
			pr_hh_s4 <= pr_hh_d;
			pr_hl_s4 <= pr_hl_d;
			pr_lh_s4 <= pr_lh_d;
			pr_ll_s4 <= pr_ll_d;
			rsq_s4   <= rsq_s3;
		end
	end

	// stage 5: recombine partial products into dist^2 and r^2 * len2
	always_comb begin
		for (int p = 0; p < P; p++) begin
			lhs_d[p] = (84'(pp_hh_s4[p]) << (2*H)) + (84'(pp_hl_s4[p]) << (H+1))
				+ 84'(pp_ll_s4[p]);
			rhs_d[p] = (84'(pr_hh_s4[p]) << (RL+LL)) + (84'(pr_hl_s4[p]) << RL)
				+ (84'(pr_lh_s4[p]) << LL) + 84'(pr_ll_s4[p]);
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			lhs_s5 <= lhs_d;
			rhs_s5 <= rhs_d;
			neg_s5 <= neg_s4;
		end
	end

	// stage 6: per-plane compare, any culling plane hides the sphere
	always_comb begin
		for (int p = 0; p < P; p++)
			cull_d[p] = neg_s5[p] && (lhs_s5[p] > rhs_s5[p]);
	end

	always_ff @(posedge clk) begin
		if (en6)
			visible_s6 <= ~|cull_d;
	end

	assign result.valid   = vld_s6;
	assign result.visible = visible_s6;

	// checks on the pipeline control
	`FSC_ASSERT(a_full_when_blocked, clk, arst_n, !sphere.ready |-> (vld_s1 && vld_s6 && !result.ready), "input blocked without a full stalled pipeline")
	`FSC_ASSERT_NEXT(a_take_enters_s1, clk, arst_n, sphere.valid && sphere.ready, vld_s1, "accepted transaction missing from stage one")
	`FSC_ASSERT_NEXT(a_s5_moves_out, clk, arst_n, vld_s5 && en6, result.valid, "stage five transaction lost on its way to the output")

endmodule
